// ===== rtl/tfd_pkg.sv =====
package tfd_pkg;

    localparam int MAX_RESULTS = 15;
    localparam int EMIT_W      = 4;
    localparam int TS_MAX      = 4;

    // per-frame data pulled out of the byte stream by the front end
    typedef struct packed {
        logic [31:0] rel;
        logic [7:0]  aux;
    } frame_meta_t;

    typedef struct packed {
        logic payload_we;
        logic commit;
    } front_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic pop;
    } back_ctl_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FLUSH
    } back_state_t;

endpackage

// ===== rtl/trace_frame_deformatter.sv =====
// Front end takes one raw byte per cycle while a frame slot is free (two slots).
// Back end walks each frame's payload RAM one byte per cycle
// while the output side does not stall it.
// A frame's first word passes the queue's count, RAM read, held-back and output registers.
// Reset (async, active low) clears counters, source IDs, flag and timestamp;
// the payload RAM is not cleared and needs no clearing pass.
module trace_frame_deformatter import tfd_pkg::*; #(
    parameter int TIMESTAMP_BYTES = 4,
    parameter int FRAME_BYTES     = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  raw_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  source_id,
    output logic [7:0]  data_byte,
    output logic [63:0] time_tag,
    output logic        frame_end
);

    localparam int PAYLOAD_BYTES = FRAME_BYTES - TIMESTAMP_BYTES - 1;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    front_ctl_t       fctl;
    back_ctl_t        bctl;
    frame_meta_t      wr_meta;
    frame_meta_t      rd_meta;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       wr_data;
    logic [7:0]       rd_data;
    logic             slot_free;
    logic             avail;

    tfd_front #(
        .TIMESTAMP_BYTES (TIMESTAMP_BYTES),
        .FRAME_BYTES     (FRAME_BYTES),
        .IDX_W           (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_byte  (raw_byte),
        .slot_free (slot_free),
        .ctl       (fctl),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .wr_meta   (wr_meta)
    );

    tfd_frame_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .fctl      (fctl),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .wr_meta   (wr_meta),
        .slot_free (slot_free),
        .bctl      (bctl),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .rd_meta   (rd_meta),
        .avail     (avail)
    );

    tfd_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .rd_meta   (rd_meta),
        .rd_data   (rd_data),
        .bctl      (bctl),
        .rd_idx    (rd_idx),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .source_id (source_id),
        .data_byte (data_byte),
        .time_tag  (time_tag),
        .frame_end (frame_end)
    );

endmodule

// ===== rtl/tfd_front.sv =====
module tfd_front import tfd_pkg::*; #(
    parameter int TIMESTAMP_BYTES = 4,
    parameter int FRAME_BYTES     = 20,
    parameter int IDX_W           = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       raw_byte,
    input  logic             slot_free,
    output front_ctl_t       ctl,
    output logic [IDX_W-1:0] wr_idx,
    output logic [7:0]       wr_data,
    output frame_meta_t      wr_meta
);

    localparam int CW = $clog2(FRAME_BYTES);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rel_reg, rel_next;
    logic [CW-1:0] payload_pos;
    logic          accept;
    logic          is_ts;
    logic          is_aux;

    assign in_ready    = slot_free;
    assign accept      = in_valid && slot_free;
    assign is_ts       = cnt_reg < CW'(TIMESTAMP_BYTES);
    assign is_aux      = cnt_reg == CW'(FRAME_BYTES - 1);
    assign payload_pos = cnt_reg - CW'(TIMESTAMP_BYTES);

    always_comb
    begin
        cnt_next = cnt_reg;
        rel_next = rel_reg;
        if (accept)
        begin
            cnt_next = is_aux ? '0 : cnt_reg + CW'(1);
            if (is_ts)
            begin
                for (int k = 0; k < TS_MAX; k++)
                begin
                    if (cnt_reg == CW'(k))
                    begin
                        rel_next[8*k +: 8] = raw_byte;
                    end
                end
            end
            if (is_aux)
            begin
                rel_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rel_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rel_reg <= rel_next;
        end
    end

    assign ctl.payload_we = accept && !is_ts && !is_aux;
    assign ctl.commit     = accept && is_aux;
    assign wr_idx         = payload_pos[IDX_W-1:0];
    assign wr_data        = raw_byte;
    assign wr_meta.rel    = rel_reg;
    assign wr_meta.aux    = raw_byte;

endmodule

// ===== rtl/tfd_frame_queue.sv =====
module tfd_frame_queue import tfd_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  front_ctl_t       fctl,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [7:0]       wr_data,
    input  frame_meta_t      wr_meta,
    output logic             slot_free,
    input  back_ctl_t        bctl,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_data,
    output frame_meta_t      rd_meta,
    output logic             avail
);

    localparam int DEPTH = 2 ** (IDX_W + 1);

    logic [7:0]  mem [DEPTH];
    frame_meta_t meta_reg [2];
    logic [7:0]  rd_data_reg;
    logic        wr_slot_reg, wr_slot_next;
    logic        rd_slot_reg, rd_slot_next;
    logic [1:0]  count_reg, count_next;

    // two frame slots; payload bytes live in the RAM, prefix and aux in flops
    always_ff @(posedge clk)
    begin
        if (fctl.payload_we)
        begin
            mem[{wr_slot_reg, wr_idx}] <= wr_data;
        end
        if (bctl.rd_en)
        begin
            rd_data_reg <= mem[{rd_slot_reg, rd_idx}];
        end
        if (fctl.commit)
        begin
            meta_reg[wr_slot_reg] <= wr_meta;
        end
    end

    always_comb
    begin
        wr_slot_next = fctl.commit ? !wr_slot_reg : wr_slot_reg;
        rd_slot_next = bctl.pop ? !rd_slot_reg : rd_slot_reg;
        count_next   = count_reg + {1'b0, fctl.commit} - {1'b0, bctl.pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg <= 1'b0;
            rd_slot_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            count_reg   <= count_next;
        end
    end

    assign slot_free = count_reg != 2'd2;
    assign avail     = count_reg != 2'd0;
    assign rd_data   = rd_data_reg;
    assign rd_meta   = meta_reg[rd_slot_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("frame queue count out of range");

    a_no_commit_full: assert property (@(posedge clk) disable iff (!rst_n)
        fctl.commit |-> count_reg != 2'd2)
        else $error("frame committed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bctl.pop |-> count_reg != 2'd0)
        else $error("frame popped from empty queue");

endmodule

// ===== rtl/tfd_back.sv =====
module tfd_back import tfd_pkg::*; #(
    parameter int PAYLOAD_BYTES = 15,
    parameter int IDX_W         = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             avail,
    input  frame_meta_t      rd_meta,
    input  logic [7:0]       rd_data,
    output back_ctl_t        bctl,
    output logic [IDX_W-1:0] rd_idx,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [6:0]       source_id,
    output logic [7:0]       data_byte,
    output logic [63:0]      time_tag,
    output logic             frame_end
);

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        aux_reg, aux_next;
    logic [6:0]        cur_reg, cur_next;
    logic [6:0]        prev_reg, prev_next;
    logic              steer_reg, steer_next;
    logic [63:0]       acc_reg, acc_next;
    logic [EMIT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [6:0]        pend_id_reg, pend_id_next;
    logic [7:0]        pend_data_reg, pend_data_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        out_id_reg, out_id_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic [63:0]       out_time_reg, out_time_next;
    logic              out_end_reg, out_end_next;

    logic       even;
    logic       id_chg;
    logic       do_emit;
    logic       out_free;
    logic       last_idx;
    logic       step;
    logic       flush_go;
    logic [6:0] item_id;
    logic [7:0] item_data;

    assign even      = !idx_reg[0];
    assign id_chg    = even && rd_data[0];
    assign do_emit   = !id_chg && (emit_cnt_reg != EMIT_W'(MAX_RESULTS));
    assign item_id   = (!even && steer_reg) ? prev_reg : cur_reg;
    assign item_data = even ? {rd_data[7:1], aux_reg[0]} : rd_data;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_idx  = idx_reg == IDX_W'(PAYLOAD_BYTES - 1);
    // one result is held back so the frame's final one can be marked
    assign step      = (state_reg == BK_WALK) && (!(do_emit && pend_valid_reg) || out_free);
    assign flush_go  = (state_reg == BK_FLUSH) && (!pend_valid_reg || out_free);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (avail)
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (step && last_idx)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bctl            = '0;
        rd_idx          = '0;
        idx_next        = idx_reg;
        aux_next        = aux_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steer_next      = steer_reg;
        acc_next        = acc_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_id_next     = out_id_reg;
        out_data_next   = out_data_reg;
        out_time_next   = out_time_reg;
        out_end_next    = out_end_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (avail)
                begin
                    bctl.rd_en    = 1'b1;
                    idx_next      = '0;
                    aux_next      = rd_meta.aux;
                    acc_next      = acc_reg + {32'b0, rd_meta.rel};
                    emit_cnt_next = '0;
                end
            end
            BK_WALK:
            begin
                if (step)
                begin
                    if (!last_idx)
                    begin
                        bctl.rd_en = 1'b1;
                        rd_idx     = idx_reg + IDX_W'(1);
                        idx_next   = idx_reg + IDX_W'(1);
                    end
                    if (even)
                    begin
                        aux_next = {1'b0, aux_reg[7:1]};
                    end
                    else
                    begin
                        steer_next = 1'b0;
                    end
                    if (id_chg)
                    begin
                        prev_next  = cur_reg;
                        cur_next   = rd_data[7:1];
                        steer_next = aux_reg[0];
                    end
                    if (do_emit)
                    begin
                        emit_cnt_next   = emit_cnt_reg + EMIT_W'(1);
                        pend_valid_next = 1'b1;
                        pend_id_next    = item_id;
                        pend_data_next  = item_data;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = pend_id_reg;
                            out_data_next  = pend_data_reg;
                            out_time_next  = acc_reg;
                            out_end_next   = 1'b0;
                        end
                    end
                end
            end
            BK_FLUSH:
            begin
                if (flush_go)
                begin
                    bctl.pop = 1'b1;
                    if (pend_valid_reg)
                    begin
                        pend_valid_next = 1'b0;
                        out_valid_next  = 1'b1;
                        out_id_next     = pend_id_reg;
                        out_data_next   = pend_data_reg;
                        out_time_next   = acc_reg;
                        out_end_next    = 1'b1;
                    end
                end
            end
            default:
            begin
                bctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            idx_reg        <= '0;
            aux_reg        <= '0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            steer_reg      <= 1'b0;
            acc_reg        <= '0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            aux_reg        <= aux_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            steer_reg      <= steer_next;
            acc_reg        <= acc_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        pend_data_reg <= pend_data_next;
        out_id_reg    <= out_id_next;
        out_data_reg  <= out_data_next;
        out_time_reg  <= out_time_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign source_id = out_id_reg;
    assign data_byte = out_data_reg;
    assign time_tag  = out_time_reg;
    assign frame_end = out_end_reg;

    a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= EMIT_W'(MAX_RESULTS))
        else $error("emit count above frame limit");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> !pend_valid_reg)
        else $error("held word left over between frames");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg &&
            $stable({out_id_reg, out_data_reg, out_time_reg, out_end_reg})))
        else $error("output word changed while stalled");

endmodule

// ===== tb/sv/tb_trace_frame_deformatter.sv =====
module tb_trace_frame_deformatter import tfd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TS_BYTES  = 4;
    localparam int FRAME_LEN = 20;

    typedef logic [7:0] frame_t [FRAME_LEN];

    typedef struct packed {
        logic [6:0]  sid;
        logic [7:0]  data;
        logic [63:0] tag;
        logic        last;
    } out_word_t;

    // directed frame: relative stamp, fill bytes for even/odd payload slots,
    // the final even slot, aux byte, and optionally the literal result
    typedef struct packed {
        logic [31:0] rel;
        logic [7:0]  even_b;
        logic [7:0]  odd_b;
        logic [7:0]  last_even;
        logic [7:0]  aux;
        logic        lit;
        logic [6:0]  lit_id;
        logic [7:0]  lit_even;
        logic [7:0]  lit_odd;
        logic [63:0] lit_tag;
    } dir_row_t;

    localparam int DIR_COUNT = 6;
    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        // all zero right after reset
        '{32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 7'h00, 8'h00, 8'h00, 64'h0},
        // max stamp, every aux bit set into the data bytes
        '{32'hffff_ffff, 8'h00, 8'h00, 8'h00, 8'hff,
          1'b1, 7'h00, 8'h01, 8'h00, 64'h0000_0000_ffff_ffff},
        // carry into the upper half of the timestamp
        '{32'h1, 8'hfe, 8'hff, 8'hfe, 8'h00,
          1'b1, 7'h00, 8'hfe, 8'hff, 64'h0000_0001_0000_0000},
        // every even slot switches to ID 0x7f
        '{32'h1234_5678, 8'hff, 8'h5a, 8'hff, 8'h55, 1'b0, 7'h0, 8'h0, 8'h0, 64'h0},
        // last ID change with aux set: steer flag carries into next frame
        '{32'h0, 8'h03, 8'ha5, 8'h01, 8'h80, 1'b0, 7'h0, 8'h0, 8'h0, 64'h0},
        '{32'h7, 8'h00, 8'h3c, 8'h00, 8'h00, 1'b0, 7'h0, 8'h0, 8'h0, 64'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  raw_byte;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  source_id;
    logic [7:0]  data_byte;
    logic [63:0] time_tag;
    logic        frame_end;

    // decoder state mirror
    logic [7:0]  frame_buf [FRAME_LEN];
    int          fill;
    logic [6:0]  cur_src;
    logic [6:0]  prev_src;
    logic        steer;
    logic [63:0] ts_acc;

    out_word_t   frame_words [$];
    out_word_t   pending_words [$];
    dir_row_t    lit_row;
    logic        lit_armed;

    int send_idle;
    int recv_stall;
    int err_count;
    int words_checked;
    int frames_done;

    trace_frame_deformatter #(
        .TIMESTAMP_BYTES(TS_BYTES),
        .FRAME_BYTES    (FRAME_LEN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .raw_byte (raw_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .source_id(source_id),
        .data_byte(data_byte),
        .time_tag (time_tag),
        .frame_end(frame_end)
    );

    always #2 clk = ~clk;

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void add_word(logic [6:0] sid, logic [7:0] data);
        out_word_t w;
        if (frame_words.size() >= MAX_RESULTS)
            return;
        w.sid  = sid;
        w.data = data;
        w.tag  = ts_acc;
        w.last = 1'b0;
        frame_words.push_back(w);
    endfunction

    function automatic void decode_frame();
        logic [31:0] rel;
        logic [7:0]  aux;
        logic [7:0]  b;
        out_word_t   w;
        rel = '0;
        for (int k = 0; k < TS_BYTES && k < 4; k++)
            rel[8*k +: 8] = frame_buf[k];
        ts_acc += {32'h0, rel};
        aux = frame_buf[FRAME_LEN-1];
        frame_words.delete();
        for (int i = TS_BYTES; i + 1 < FRAME_LEN; i++)
        begin
            b = frame_buf[i];
            if (i % 2 == 0)
            begin
                if (b[0])
                begin
                    prev_src = cur_src;
                    cur_src  = b[7:1];
                    steer    = aux[0];
                end
                else
                begin
                    add_word(cur_src, {b[7:1], aux[0]});
                end
                aux = aux >> 1;
            end
            else if (steer)
            begin
                add_word(prev_src, b);
                steer = 1'b0;
            end
            else
            begin
                add_word(cur_src, b);
            end
        end
        if (frame_words.size() > 0)
            frame_words[frame_words.size()-1].last = 1'b1;
        // rows with hand-written results replace the computed words
        if (lit_armed)
        begin
            frame_words.delete();
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                w.sid  = lit_row.lit_id;
                w.data = ((TS_BYTES + k) % 2 == 0) ? lit_row.lit_even : lit_row.lit_odd;
                w.tag  = lit_row.lit_tag;
                w.last = (k == MAX_RESULTS - 1);
                frame_words.push_back(w);
            end
            lit_armed = 1'b0;
        end
        foreach (frame_words[k])
            pending_words.push_back(frame_words[k]);
        frames_done++;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        frame_buf[fill] = b;
        fill++;
        if (fill == FRAME_LEN)
        begin
            fill = 0;
            decode_frame();
        end
    endfunction

    function automatic frame_t expand_row(dir_row_t r);
        frame_t f;
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            if (k < TS_BYTES)
                f[k] = r.rel[8*k +: 8];
            else if (k == FRAME_LEN - 1)
                f[k] = r.aux;
            else if (k == FRAME_LEN - 2)
                f[k] = r.last_even;
            else
                f[k] = (k % 2 == 0) ? r.even_b : r.odd_b;
        end
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     style;
        style = int'($urandom_range(7));
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            f[k] = 8'($urandom_range(255));
            if (k < TS_BYTES && style == 0)
                f[k] = 8'hff;
            else if (k < TS_BYTES && style == 1)
                f[k] = 8'h00;
            else if (k >= TS_BYTES && k < FRAME_LEN - 1 && k % 2 == 0)
            begin
                if (style == 2)
                    f[k][0] = 1'b0;     // data only
                else if (style == 3)
                    f[k][0] = 1'b1;     // ID changes only
            end
        end
        // ID change on the last even slot with its aux bit set
        if (style == 4)
        begin
            f[FRAME_LEN-2][0] = 1'b1;
            f[FRAME_LEN-1][(FRAME_LEN-2-TS_BYTES)/2] = 1'b1;
        end
        return f;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        raw_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        store_byte(b);
    endtask

    task automatic send_frame(input frame_t f);
        for (int k = 0; k < FRAME_LEN; k++)
            send_byte(f[k]);
    endtask

    // hold the input off until every queued word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                note_error($sformatf("unexpected word id=%h data=%h tag=%h end=%b",
                                     source_id, data_byte, time_tag, frame_end));
            end
            else
            begin
                want = pending_words.pop_front();
                if (source_id !== want.sid || data_byte !== want.data ||
                    time_tag !== want.tag || frame_end !== want.last)
                    note_error($sformatf(
                        "word %0d: exp id=%h data=%h tag=%h end=%b, got id=%h data=%h tag=%h end=%b",
                        words_checked, want.sid, want.data, want.tag, want.last,
                        source_id, data_byte, time_tag, frame_end));
                words_checked++;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall);
    end

    initial
    begin
        #2_000_000;
        $display("[trace_frame_deformatter] ERROR");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        raw_byte      = 8'h00;
        out_ready     = 1'b0;
        fill          = 0;
        cur_src       = '0;
        prev_src      = '0;
        steer         = 1'b0;
        ts_acc        = '0;
        lit_armed     = 1'b0;
        lit_row       = '0;
        err_count     = 0;
        words_checked = 0;
        frames_done   = 0;
        send_idle     = 6;
        recv_stall    = 65;
        foreach (frame_buf[k])
            frame_buf[k] = 8'h00;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_COUNT; r++)
        begin
            lit_row   = DIR_ROWS[r];
            lit_armed = DIR_ROWS[r].lit;
            send_frame(expand_row(DIR_ROWS[r]));
        end
        drain();

        for (int p = 0; p < 3; p++)
        begin
            send_idle  = (p == 0) ? 6 : (p == 1) ? 65 : 0;
            recv_stall = (p == 0) ? 65 : (p == 1) ? 6 : 0;
            for (int n = 0; n < 5; n++)
                send_frame(random_frame());
            if (p < 2)
                drain();
        end
        // trailing partial frame: accepted but never decoded
        for (int k = 0; k < 10; k++)
            send_byte(8'($urandom_range(255)));

        drain();
        repeat (60) @(posedge clk);

        $display("decoded %0d frames (%0d directed), checked %0d data words",
                 frames_done, DIR_COUNT, words_checked);
        $display("idle mixes: light/heavy, heavy/light and back-to-back; %0d errors",
                 err_count);
        if (err_count == 0)
            $display("[trace_frame_deformatter] OK");
        else
            $display("[trace_frame_deformatter] ERROR");
        $finish;
    end

endmodule
